[rtl/core/qba_pkg.sv]
`timescale 1ns / 1ps

package qba_pkg;

  // Field widths
  localparam int unsigned ValueWidth = 8;
  localparam int unsigned MultWidth  = 31;
  localparam int unsigned ShiftWidth = 5;
  localparam int unsigned ShiftsRegWidth = 3 * ShiftWidth;
  localparam int unsigned CfgDataWidth = 31;
  localparam int unsigned CfgIndexWidth = 3;

  // Register stages from request to result
  localparam int unsigned PipeDepth = 7;

  // Configuration register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_INPUT_ZP   = 3'd0,
    REG_BIAS_ZP    = 3'd1,
    REG_OUTPUT_ZP  = 3'd2,
    REG_INPUT_MULT = 3'd3,
    REG_BIAS_MULT  = 3'd4,
    REG_OUTPUT_MULT = 3'd5,
    REG_RIGHT_SHIFTS = 3'd6
  } qba_reg_t;

  localparam logic [MultWidth-1:0] MultReset = 31'h4000_0000;

  // Divide by 2^e, round half away from zero.
  function automatic logic signed [31:0] round_shift(input logic signed [31:0] x,
                                                     input logic [ShiftWidth-1:0] e);
    logic signed [31:0] fl;
    logic [31:0] mask;
    logic [31:0] rem;
    logic [31:0] thr;
    fl   = x >>> e;
    mask = (32'd1 << e) - 32'd1;
    rem  = x & mask;
    thr  = (mask >> 1) + {31'd0, x[31]};
    return fl + ((rem > thr) ? 32'sd1 : 32'sd0);
  endfunction

endpackage

[rtl/core/qba_in_if.sv]
`timescale 1ns / 1ps

interface qba_in_if;
  logic                             valid;
  logic                             ready;
  logic [qba_pkg::ValueWidth-1:0]   input_value;
  logic [qba_pkg::ValueWidth-1:0]   bias_value;

  modport source (output valid, output input_value, output bias_value, input ready);
  modport sink   (input valid, input input_value, input bias_value, output ready);
endinterface

[rtl/core/qba_out_if.sv]
`timescale 1ns / 1ps

interface qba_out_if;
  logic                             valid;
  logic                             ready;
  logic [qba_pkg::ValueWidth-1:0]   output_value;

  modport source (output valid, output output_value, input ready);
  modport sink   (input valid, input output_value, output ready);
endinterface

[rtl/core/quantized_u8_bias_add.sv]
`timescale 1ns / 1ps

// Requantizing uint8 add of an input value and its bias. Each request takes
// one input_value/bias_value pair and yields one clamped uint8 output_value,
// in order. The datapath is a seven-stage pipeline, and a request enters every
// cycle unless the result side stalls and the stages have filled. Each stage
// holds its own valid bit and loads whenever it is empty or the stage after
// it moves, so bubbles close up and the operand side keeps taking requests
// while a finished result waits in the output register, until every stage is
// full. Throughput is one request per cycle while nothing stalls; the seven
// register stages split the three multipliers and the rounding shifts between
// them.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data
// and must only change while no request is in flight. Index 7 is ignored.
module quantized_u8_bias_add (
  input  logic                                clk,
  input  logic                                rst,
  qba_in_if.sink                              operand,
  qba_out_if.source                           result,
  input  logic                                cfg_wr_en,
  input  logic [qba_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [qba_pkg::CfgDataWidth-1:0]    cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [qba_pkg::ValueWidth-1:0]     input_zp;
  logic [qba_pkg::ValueWidth-1:0]     bias_zp;
  logic [qba_pkg::ValueWidth-1:0]     output_zp;
  logic [qba_pkg::MultWidth-1:0]      input_mult;
  logic [qba_pkg::MultWidth-1:0]      bias_mult;
  logic [qba_pkg::MultWidth-1:0]      output_mult;
  logic [qba_pkg::ShiftsRegWidth-1:0] right_shifts;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_zp     <= '0;
      bias_zp      <= '0;
      output_zp    <= '0;
      input_mult   <= qba_pkg::MultReset;
      bias_mult    <= qba_pkg::MultReset;
      output_mult  <= qba_pkg::MultReset;
      right_shifts <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        qba_pkg::REG_INPUT_ZP:     input_zp     <= cfg_data[qba_pkg::ValueWidth-1:0];
        qba_pkg::REG_BIAS_ZP:      bias_zp      <= cfg_data[qba_pkg::ValueWidth-1:0];
        qba_pkg::REG_OUTPUT_ZP:    output_zp    <= cfg_data[qba_pkg::ValueWidth-1:0];
        qba_pkg::REG_INPUT_MULT:   input_mult   <= cfg_data[qba_pkg::MultWidth-1:0];
        qba_pkg::REG_BIAS_MULT:    bias_mult    <= cfg_data[qba_pkg::MultWidth-1:0];
        qba_pkg::REG_OUTPUT_MULT:  output_mult  <= cfg_data[qba_pkg::MultWidth-1:0];
        qba_pkg::REG_RIGHT_SHIFTS: right_shifts <= cfg_data[qba_pkg::ShiftsRegWidth-1:0];
        default: ;
      endcase
    end
  end

  logic [qba_pkg::ShiftWidth-1:0] input_sh;
  logic [qba_pkg::ShiftWidth-1:0] bias_sh;
  logic [qba_pkg::ShiftWidth-1:0] output_sh;

  assign input_sh  = right_shifts[4:0];
  assign bias_sh   = right_shifts[9:5];
  assign output_sh = right_shifts[14:10];

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when it drains.
  // ---------------------------------------------------------------------
  logic [qba_pkg::PipeDepth-1:0] vld;
  logic [qba_pkg::PipeDepth-1:0] en;

  always_comb begin
    en[qba_pkg::PipeDepth-1] = !vld[qba_pkg::PipeDepth-1] || result.ready;
    for (int k = qba_pkg::PipeDepth - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign operand.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= operand.valid;
      end
      for (int k = 1; k < qba_pkg::PipeDepth; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: subtract zero points and multiply. The 2^20 pre-scale is
  // folded into the SRDHM shift below: (p*2^20 + 2^30) >> 31 equals
  // (p + 2^10) >> 11, and floor division covers both signs of the nudge.
  // ---------------------------------------------------------------------
  logic signed [8:0]  off_i;
  logic signed [8:0]  off_b;
  logic signed [39:0] prod_i_next;
  logic signed [39:0] prod_b_next;
  logic signed [39:0] prod_i;
  logic signed [39:0] prod_b;

  assign off_i = $signed({1'b0, operand.input_value}) - $signed({1'b0, input_zp});
  assign off_b = $signed({1'b0, operand.bias_value}) - $signed({1'b0, bias_zp});
  assign prod_i_next = off_i * $signed({1'b0, input_mult});
  assign prod_b_next = off_b * $signed({1'b0, bias_mult});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_i <= prod_i_next;
      prod_b <= prod_b_next;
    end
  end

  // Stage 2: rounding high part of the operand products
  logic signed [39:0] rnd_i;
  logic signed [39:0] rnd_b;
  logic signed [28:0] hi_i;
  logic signed [28:0] hi_b;

  assign rnd_i = prod_i + 40'sd1024;
  assign rnd_b = prod_b + 40'sd1024;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hi_i <= rnd_i[39:11];
      hi_b <= rnd_b[39:11];
    end
  end

  // Stage 3: rounding right shift of each operand
  logic signed [31:0] sc_i_next;
  logic signed [31:0] sc_b_next;
  logic signed [28:0] sc_i;
  logic signed [28:0] sc_b;

  assign sc_i_next = qba_pkg::round_shift(32'(hi_i), input_sh);
  assign sc_b_next = qba_pkg::round_shift(32'(hi_b), bias_sh);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sc_i <= sc_i_next[28:0];
      sc_b <= sc_b_next[28:0];
    end
  end

  // Stage 4: sum; both operands stay within 29 bits, so no wrap occurs
  logic signed [29:0] sum;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sum <= 30'(sc_i) + 30'(sc_b);
    end
  end

  // Stage 5: output multiply
  logic signed [60:0] prod_o;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      prod_o <= sum * $signed({1'b0, output_mult});
    end
  end

  // Stage 6: rounding high part of the output product
  logic signed [60:0] rnd_o;
  logic signed [29:0] hi_o;

  assign rnd_o = prod_o + 61'sh4000_0000;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      hi_o <= rnd_o[60:31];
    end
  end

  // Stage 7: rounding shift, output zero point, clamp to 0..255
  logic signed [31:0] sh_o;
  logic signed [32:0] biased;
  logic [qba_pkg::ValueWidth-1:0] out_val_next;
  logic [qba_pkg::ValueWidth-1:0] out_val;

  assign sh_o   = qba_pkg::round_shift(32'(hi_o), output_sh);
  assign biased = 33'(sh_o) + $signed({25'd0, output_zp});

  always_comb begin
    if (biased < 33'sd0) begin
      out_val_next = '0;
    end else if (biased > 33'sd255) begin
      out_val_next = '1;
    end else begin
      out_val_next = biased[qba_pkg::ValueWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      out_val <= out_val_next;
    end
  end

  assign result.valid        = vld[qba_pkg::PipeDepth-1];
  assign result.output_value = out_val;

endmodule

[rtl/core/qba_checker.sv]
`timescale 1ns / 1ps

module qba_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              op_valid,
  input logic                              op_ready,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic [qba_pkg::ValueWidth-1:0]    res_value
);

  logic req_acc;
  logic res_acc;
  logic [3:0] outstanding;

  assign req_acc = op_valid && op_ready;
  assign res_acc = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + {3'd0, req_acc} - {3'd0, res_acc};
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_value))
    else $error("stalled result changed or dropped");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> outstanding != 4'd0)
    else $error("result without a pending request");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 4'(qba_pkg::PipeDepth))
    else $error("more requests in flight than pipeline stages");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    res_ready |-> op_ready)
    else $error("operand side stalled while result side drains");

endmodule

bind quantized_u8_bias_add qba_checker u_qba_checker (
  .clk       (clk),
  .rst       (rst),
  .op_valid  (operand.valid),
  .op_ready  (operand.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_value (result.output_value)
);

[test/quantized_u8_bias_add_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the requantizing uint8 add. Operand requests are
// queued by the sequencer, driven by a clocked driver, and predicted at the
// edge where they are accepted. Results are compared in order against the
// predicted outputs.
module quantized_u8_bias_add_test;

  // Fixed pre-scale applied to each operand before its multiplier
  localparam int unsigned PreShift = 20;
  // Index beyond the register file; the block must drop writes to it
  localparam logic [qba_pkg::CfgIndexWidth-1:0] UnusedRegIndex = 3'd7;
  localparam int unsigned PhaseCount = 9;
  localparam int unsigned RandomPerPhase = 111;
  // Receiver hold-off long enough to fill the whole pipeline
  localparam int unsigned LongStall = 80;
  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned MaxPrinted = 40;

  typedef struct {
    logic [qba_pkg::ValueWidth-1:0] input_value;
    logic [qba_pkg::ValueWidth-1:0] bias_value;
  } operand_req_t;

  typedef struct {
    logic [qba_pkg::ValueWidth-1:0] input_value;
    logic [qba_pkg::ValueWidth-1:0] bias_value;
    logic [qba_pkg::ValueWidth-1:0] output_value;
  } predicted_out_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [qba_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [qba_pkg::CfgDataWidth-1:0] cfg_data;

  qba_in_if  operand_bus ();
  qba_out_if result_bus ();

  quantized_u8_bias_add uut (
    .clk       (clk),
    .rst       (rst),
    .operand   (operand_bus.sink),
    .result    (result_bus.source),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Local copy of the register file, updated as each write is driven. Writes
  // only happen while the block is empty, so predicting with these values at
  // acceptance time matches what the hardware sees.
  logic [qba_pkg::ValueWidth-1:0] model_in_zp;
  logic [qba_pkg::ValueWidth-1:0] model_bias_zp;
  logic [qba_pkg::ValueWidth-1:0] model_out_zp;
  logic [qba_pkg::MultWidth-1:0] model_in_mult;
  logic [qba_pkg::MultWidth-1:0] model_bias_mult;
  logic [qba_pkg::MultWidth-1:0] model_out_mult;
  logic [qba_pkg::ShiftsRegWidth-1:0] model_shifts;

  operand_req_t operand_requests[$];
  predicted_out_t predicted_outputs[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  // Toggled by the sequencer; the receiver answers with one long hold-off
  logic stall_req;
  logic stall_ack;
  int unsigned stall_left;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Q31 doubling high multiply with rounding; the product is truncated
  // toward zero after the nudge. The saturating corner needs a multiplier
  // of 2^31, which a 31-bit register cannot hold.
  function automatic longint q31_high_mul(longint a, logic [qba_pkg::MultWidth-1:0] m);
    longint mult;
    longint prod;
    longint nudge;
    mult = m;
    prod = a * mult;
    nudge = (prod >= 0) ? (longint'(1) << 30) : (longint'(1) - (longint'(1) << 30));
    return (prod + nudge) / (longint'(1) << 31);
  endfunction

  // Divide by 2^e, ties rounded away from zero
  function automatic longint round_half_away(longint x, int unsigned e);
    longint fl;
    longint rem;
    longint mask;
    longint thr;
    fl = x >>> e;
    rem = x - (fl <<< e);
    mask = (longint'(1) << e) - 1;
    thr = (mask >>> 1) + ((x < 0) ? 1 : 0);
    return fl + ((rem > thr) ? 1 : 0);
  endfunction

  function automatic longint scale_operand(logic [qba_pkg::ValueWidth-1:0] v,
                                           logic [qba_pkg::ValueWidth-1:0] zp,
                                           logic [qba_pkg::MultWidth-1:0] m,
                                           int unsigned sh);
    longint diff;
    diff = longint'(v) - longint'(zp);
    return round_half_away(q31_high_mul(diff * (longint'(1) << PreShift), m), sh);
  endfunction

  function automatic logic [qba_pkg::ValueWidth-1:0] requantize_pair(
      logic [qba_pkg::ValueWidth-1:0] iv, logic [qba_pkg::ValueWidth-1:0] bv);
    longint a;
    longint b;
    longint r;
    int wrapped;
    a = scale_operand(iv, model_in_zp, model_in_mult, model_shifts[4:0]);
    b = scale_operand(bv, model_bias_zp, model_bias_mult, model_shifts[9:5]);
    // 32-bit two's complement wrap of the operand sum
    wrapped = int'(a + b);
    r = round_half_away(q31_high_mul(longint'(wrapped), model_out_mult), model_shifts[14:10])
        + longint'(model_out_zp);
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r[qba_pkg::ValueWidth-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------
  // Operand driver: holds a request until it is taken, then offers the next
  // one or idles. The prediction is made at the accepting edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_operands
    operand_req_t next_req;
    predicted_out_t pred;
    if (rst) begin
      operand_bus.valid <= 1'b0;
    end else begin
      if (operand_bus.valid && operand_bus.ready) begin
        pred.input_value = operand_bus.input_value;
        pred.bias_value = operand_bus.bias_value;
        pred.output_value = requantize_pair(operand_bus.input_value, operand_bus.bias_value);
        predicted_outputs.push_back(pred);
      end
      if (!operand_bus.valid || operand_bus.ready) begin
        if (operand_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_req = operand_requests.pop_front();
          operand_bus.valid <= 1'b1;
          operand_bus.input_value <= next_req.input_value;
          operand_bus.bias_value <= next_req.bias_value;
        end else begin
          operand_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result receiver: random back-pressure, plus one long hold-off on request
  // so the pipeline fills and the operand side has to stall.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      stall_left <= 0;
      stall_ack <= 1'b0;
    end else if (stall_left != 0) begin
      result_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_ack != stall_req) begin
      result_bus.ready <= 1'b0;
      stall_left <= LongStall;
      stall_ack <= stall_req;
    end else begin
      result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result monitor: in-order compare against the oldest prediction
  always @(posedge clk) begin : check_results
    predicted_out_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (predicted_outputs.size() == 0) begin
        report_mismatch($sformatf("output_value %0d with no request outstanding",
                                  result_bus.output_value));
      end else begin
        want = predicted_outputs.pop_front();
        if (result_bus.output_value !== want.output_value)
          report_mismatch($sformatf("output_value %0d, predicted %0d (input %0d bias %0d)",
                                    result_bus.output_value, want.output_value,
                                    want.input_value, want.bias_value));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------

  // Drives one register write at the next edge; enable stays high so
  // back-to-back writes need no gap. Model keeps only the register's bits.
  task automatic write_reg(logic [qba_pkg::CfgIndexWidth-1:0] idx,
                           logic [qba_pkg::CfgDataWidth-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      qba_pkg::REG_INPUT_ZP:     model_in_zp = data[qba_pkg::ValueWidth-1:0];
      qba_pkg::REG_BIAS_ZP:      model_bias_zp = data[qba_pkg::ValueWidth-1:0];
      qba_pkg::REG_OUTPUT_ZP:    model_out_zp = data[qba_pkg::ValueWidth-1:0];
      qba_pkg::REG_INPUT_MULT:   model_in_mult = data[qba_pkg::MultWidth-1:0];
      qba_pkg::REG_BIAS_MULT:    model_bias_mult = data[qba_pkg::MultWidth-1:0];
      qba_pkg::REG_OUTPUT_MULT:  model_out_mult = data[qba_pkg::MultWidth-1:0];
      qba_pkg::REG_RIGHT_SHIFTS: model_shifts = data[qba_pkg::ShiftsRegWidth-1:0];
      default: ;
    endcase
  endtask

  // Loads the whole register file. Narrow registers get random junk in the
  // upper data bits, which the block must drop.
  task automatic load_config(logic [7:0] izp, logic [7:0] bzp, logic [7:0] ozp,
                             logic [30:0] im, logic [30:0] bm, logic [30:0] om,
                             logic [14:0] shifts);
    logic [qba_pkg::CfgDataWidth-1:0] junk;
    junk = 31'($urandom);
    write_reg(qba_pkg::REG_INPUT_ZP, {junk[30:8], izp});
    junk = 31'($urandom);
    write_reg(qba_pkg::REG_BIAS_ZP, {junk[30:8], bzp});
    junk = 31'($urandom);
    write_reg(qba_pkg::REG_OUTPUT_ZP, {junk[30:8], ozp});
    write_reg(qba_pkg::REG_INPUT_MULT, im);
    write_reg(qba_pkg::REG_BIAS_MULT, bm);
    write_reg(qba_pkg::REG_OUTPUT_MULT, om);
    junk = 31'($urandom);
    write_reg(qba_pkg::REG_RIGHT_SHIFTS, {junk[30:15], shifts});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Zero points, multipliers near unity and an output shift chosen so that
  // most sums land inside 0..255 instead of saturating.
  task automatic load_typical_config();
    logic [4:0] ish;
    logic [4:0] bsh;
    logic [4:0] osh;
    ish = 5'($urandom_range(0, 3));
    bsh = 5'($urandom_range(0, 3));
    osh = 5'($urandom_range(17, 22));
    load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)),
                31'($urandom_range(32'h2000_0000, 32'h7fff_ffff)),
                31'($urandom_range(32'h2000_0000, 32'h7fff_ffff)),
                31'($urandom_range(32'h2000_0000, 32'h7fff_ffff)), {osh, bsh, ish});
  endtask

  task automatic queue_request(logic [7:0] iv, logic [7:0] bv);
    operand_req_t req;
    req.input_value = iv;
    req.bias_value = bv;
    operand_requests.push_back(req);
  endtask

  // A quarter of the values sit near their zero point to get small sums
  task automatic queue_random(int unsigned n);
    logic [7:0] iv;
    logic [7:0] bv;
    for (int unsigned k = 0; k < n; k++) begin
      iv = ($urandom_range(0, 3) == 0) ? model_in_zp + 8'($urandom_range(0, 16)) - 8'd8
                                       : 8'($urandom_range(0, 255));
      bv = ($urandom_range(0, 3) == 0) ? model_bias_zp + 8'($urandom_range(0, 16)) - 8'd8
                                       : 8'($urandom_range(0, 255));
      queue_request(iv, bv);
    end
  endtask

  // Sequencer holds off until every request has come back; sampled away from
  // the rising edge so the driver's updates for that edge have settled
  task automatic wait_drained();
    while (operand_requests.size() != 0 || operand_bus.valid || predicted_outputs.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 18;
    recv_idle_pct = 58;
    stall_req = 1'b0;
    // Reset values of the register file
    model_in_zp = '0;
    model_bias_zp = '0;
    model_out_zp = '0;
    model_in_mult = qba_pkg::MultReset;
    model_bias_mult = qba_pkg::MultReset;
    model_out_mult = qba_pkg::MultReset;
    model_shifts = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      // Block is empty here, so the register file may change
      case (phase)
        0: ;  // reset configuration
        1: begin
          // Out-of-range index first: must not disturb anything
          write_reg(UnusedRegIndex, 31'($urandom));
          load_typical_config();
        end
        // Largest multipliers, no shifts: heavy positive saturation
        2: load_config(8'd0, 8'd0, 8'd0, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 15'h0000);
        // Zero multipliers and every shift at its maximum
        3: load_config(8'hff, 8'hff, 8'hff, 31'd0, 31'd0, 31'd0, 15'h7fff);
        4: load_typical_config();
        // Fully random register file
        5: load_config(8'($urandom), 8'($urandom), 8'($urandom), 31'($urandom),
                       31'($urandom), 31'($urandom), 15'($urandom));
        6: load_typical_config();
        // Zero multiplier on one operand path only
        7: load_config(8'($urandom), 8'($urandom), 8'($urandom), 31'd0,
                       31'($urandom_range(32'h2000_0000, 32'h7fff_ffff)),
                       31'($urandom_range(32'h2000_0000, 32'h7fff_ffff)),
                       {5'($urandom_range(16, 20)), 5'($urandom_range(0, 2)), 5'd0});
        default: load_typical_config();
      endcase

      // Back-pressure pattern: sender-light, then receiver-light, then none
      case (phase / 3)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      // Field corners, and both operands at their zero points
      queue_request(8'd0, 8'd0);
      queue_request(8'd255, 8'd255);
      queue_request(8'd0, 8'd255);
      queue_request(8'd255, 8'd0);
      queue_request(model_in_zp, model_bias_zp);
      if (phase == 0) begin
        queue_request(8'd1, 8'd0);
        queue_request(8'd0, 8'd1);
        queue_request(8'd128, 8'd128);
        queue_request(8'd127, 8'd129);
        queue_request(8'haa, 8'h55);
        queue_request(8'h55, 8'haa);
      end
      queue_random(RandomPerPhase);

      // One long receiver hold-off while the sender keeps offering
      if (phase == 4) stall_req = ~stall_req;

      wait_drained();
    end

    // Catch any stray output after the last expected one
    repeat (qba_pkg::PipeDepth * 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
